FILE: hdl/apu_fs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer package
// Shared constants, operation codes and the command and status structures
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package apu_fs_pkg;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [9:0]  MaxStepCycles = 10'd1023;

  localparam logic [14:0] Mark0 = 15'd3729;
  localparam logic [14:0] Mark1 = 15'd7457;
  localparam logic [14:0] Mark2 = 15'd11186;
  localparam logic [14:0] Mark3 = 15'd14916;
  localparam logic [14:0] End5  = 15'd18641;

  localparam logic [15:0] AddrStatus = 16'h4015;
  localparam logic [15:0] AddrFrame  = 16'h4017;

  localparam int unsigned BitInhibit = 6;
  localparam int unsigned BitMode    = 7;

  localparam logic [31:0] CyclesPerSampleReset = 32'd2443636;

  localparam int unsigned QuotBits = 6;
  localparam logic [2:0]  QuotTopBit = 3'd5;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       div_step;
    logic [2:0] div_idx;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/apu_fs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer controller
// Sequences each word through capture, execution, the sample divider steps
// when a tick needs them, and delivery to the output register.
// ----------------------------------------------------------------------------
module apu_fs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire apu_fs_pkg::status_t status_i,
  output apu_fs_pkg::cmd_t        cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.div_idx = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        if (status_i.div_needed) begin
          idx_d   = apu_fs_pkg::QuotTopBit;
          state_d = StDiv;
        end else begin
          state_d = StDone;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (idx_q == 3'd0) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q - 3'd1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/apu_fs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer datapath
// Holds the sequencer, register and sample pacing state, the restoring
// divider for the sample count and the output register.
// ----------------------------------------------------------------------------
module apu_fs_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire apu_fs_pkg::cmd_t    cmd_i,
  output apu_fs_pkg::status_t      status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [9:0]          cycles_i,
  input  wire logic [15:0]         addr_i,
  input  wire logic [7:0]          wdata_i,
  input  wire logic                pulse1_length_active_i,
  input  wire logic                pulse2_length_active_i,
  output logic [7:0]               read_data_o,
  output logic                     quarter_clock_o,
  output logic                     half_clock_o,
  output logic                     frame_irq_level_o,
  output logic [5:0]               samples_due_o,
  output logic [4:0]               channel_enable_bits_o
);

  // Captured word.
  logic [1:0]  op_q;
  logic [9:0]  cyc_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic        p1_q, p2_q;

  // Architectural state.
  logic [31:0] cps_q;
  logic [14:0] seq_q, seq_d;
  logic        five_q, five_d;
  logic        inhibit_q, inhibit_d;
  logic        irq_q, irq_d;
  logic [31:0] accum_q, accum_d;
  logic [4:0]  enables_q, enables_d;

  // Working registers.
  logic [7:0]  rdata_q, rdata_d;
  logic        quarter_q, quarter_d;
  logic        half_q, half_d;
  logic [5:0]  quot_q, quot_d;
  logic [32:0] rem_q, rem_d;

  // Output register.
  logic [7:0]  out_rdata_q;
  logic        out_quarter_q, out_half_q, out_irq_q;
  logic [5:0]  out_due_q;
  logic [4:0]  out_enables_q;

  logic [9:0]  cyc_eff;
  logic [14:0] seq_from, after, seq_end;
  logic        cross0, cross1, cross2, cross3;
  logic        is_tick;
  logic [37:0] divisor_sh;
  logic        sub_ok;
  logic [32:0] rem_sub;

  assign cyc_eff = (cyc_q > apu_fs_pkg::MaxStepCycles) ? apu_fs_pkg::MaxStepCycles : cyc_q;
  assign is_tick = (op_q == apu_fs_pkg::OpTick) && (cyc_q != 10'd0);
  assign status_o.div_needed = is_tick && (cps_q != 32'd0);

  assign seq_from = seq_q;
  assign after    = seq_q + {5'd0, cyc_eff};
  assign cross0   = (seq_from < apu_fs_pkg::Mark0) && (after >= apu_fs_pkg::Mark0);
  assign cross1   = (seq_from < apu_fs_pkg::Mark1) && (after >= apu_fs_pkg::Mark1);
  assign cross2   = (seq_from < apu_fs_pkg::Mark2) && (after >= apu_fs_pkg::Mark2);
  assign cross3   = (seq_from < apu_fs_pkg::Mark3) && (after >= apu_fs_pkg::Mark3);
  assign seq_end  = five_q ? apu_fs_pkg::End5 : apu_fs_pkg::Mark3;

  assign divisor_sh = {6'd0, cps_q} << cmd_i.div_idx;
  assign sub_ok     = {5'd0, rem_q} >= divisor_sh;
  assign rem_sub    = sub_ok ? (rem_q - divisor_sh[32:0]) : rem_q;

  always_comb begin
    seq_d     = seq_q;
    five_d    = five_q;
    inhibit_d = inhibit_q;
    irq_d     = irq_q;
    accum_d   = accum_q;
    enables_d = enables_q;
    rdata_d   = rdata_q;
    quarter_d = quarter_q;
    half_d    = half_q;
    quot_d    = quot_q;
    rem_d     = rem_q;

    if (cmd_i.exec) begin
      rdata_d   = 8'd0;
      quarter_d = 1'b0;
      half_d    = 1'b0;
      quot_d    = 6'd0;
      rem_d     = {1'b0, accum_q} + {7'd0, cyc_eff, 16'd0};
      case (op_q)
        apu_fs_pkg::OpTick: begin
          if (is_tick) begin
            quarter_d = cross0 || cross1 || cross2 || cross3;
            half_d    = cross1 || cross3;
            if (cross3 && !five_q && !inhibit_q) begin
              irq_d = 1'b1;
            end
            seq_d = (after >= seq_end) ? (after - seq_end) : after;
          end
        end
        apu_fs_pkg::OpWrite: begin
          if (addr_q == apu_fs_pkg::AddrStatus) begin
            enables_d = wdata_q[4:0];
          end else if (addr_q == apu_fs_pkg::AddrFrame) begin
            five_d    = wdata_q[apu_fs_pkg::BitMode];
            inhibit_d = wdata_q[apu_fs_pkg::BitInhibit];
            if (wdata_q[apu_fs_pkg::BitInhibit]) begin
              irq_d = 1'b0;
            end
            seq_d = 15'd0;
          end
        end
        apu_fs_pkg::OpRead: begin
          if (addr_q == apu_fs_pkg::AddrStatus) begin
            rdata_d = {1'b0, irq_q, 4'd0, p2_q, p1_q};
            irq_d   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.div_step) begin
      rem_d                 = rem_sub;
      quot_d[cmd_i.div_idx] = sub_ok;
      if (cmd_i.div_idx == 3'd0) begin
        accum_d = rem_sub[32] ? 32'hFFFF_FFFF : rem_sub[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q     <= apu_fs_pkg::CyclesPerSampleReset;
      seq_q     <= 15'd0;
      five_q    <= 1'b0;
      inhibit_q <= 1'b0;
      irq_q     <= 1'b0;
      accum_q   <= 32'd0;
      enables_q <= 5'd0;
    end else begin
      if (cfg_we_i) begin
        cps_q <= cfg_wdata_i;
      end
      seq_q     <= seq_d;
      five_q    <= five_d;
      inhibit_q <= inhibit_d;
      irq_q     <= irq_d;
      accum_q   <= accum_d;
      enables_q <= enables_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      cyc_q   <= cycles_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
      p1_q    <= pulse1_length_active_i;
      p2_q    <= pulse2_length_active_i;
    end
    rdata_q   <= rdata_d;
    quarter_q <= quarter_d;
    half_q    <= half_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    if (cmd_i.finish) begin
      out_rdata_q   <= rdata_q;
      out_quarter_q <= quarter_q;
      out_half_q    <= half_q;
      out_irq_q     <= irq_q;
      out_due_q     <= quot_q;
      out_enables_q <= enables_q;
    end
  end

  assign read_data_o           = out_rdata_q;
  assign quarter_clock_o       = out_quarter_q;
  assign half_clock_o          = out_half_q;
  assign frame_irq_level_o     = out_irq_q;
  assign samples_due_o         = out_due_q;
  assign channel_enable_bits_o = out_enables_q;

endmodule
`default_nettype wire

FILE: hdl/apu_frame_sequencer_status.sv
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer with status registers
// Each word (a tick, a register write or a register read) yields one result
// word. A write, a read, an unused operation, or a tick with no cycles or with
// a zero sample period goes from capture through execution to the output
// register. Any other tick also passes through a restoring divider that gives
// the sample count and resolves one quotient bit per cycle, six bits in all,
// before its result is delivered. In both cases the block returns to idle as
// the result is registered and can then accept the next word. A new word is
// accepted while the previous result still waits in the output register; a
// result that cannot be delivered holds the block until the output register
// is drained. The sample period register may be written at any time the
// block is idle.
// ----------------------------------------------------------------------------
module apu_frame_sequencer_status (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [9:0]  cycles_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [7:0]  wdata_i,
  input  wire logic        pulse1_length_active_i,
  input  wire logic        pulse2_length_active_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             quarter_clock_o,
  output logic             half_clock_o,
  output logic             frame_irq_level_o,
  output logic [5:0]       samples_due_o,
  output logic [4:0]       channel_enable_bits_o
);

  apu_fs_pkg::cmd_t    cmd;
  apu_fs_pkg::status_t status;

  apu_fs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  apu_fs_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .op_i                   (op_i),
    .cycles_i               (cycles_i),
    .addr_i                 (addr_i),
    .wdata_i                (wdata_i),
    .pulse1_length_active_i (pulse1_length_active_i),
    .pulse2_length_active_i (pulse2_length_active_i),
    .read_data_o            (read_data_o),
    .quarter_clock_o        (quarter_clock_o),
    .half_clock_o           (half_clock_o),
    .frame_irq_level_o      (frame_irq_level_o),
    .samples_due_o          (samples_due_o),
    .channel_enable_bits_o  (channel_enable_bits_o)
  );

endmodule
`default_nettype wire

FILE: bench/apu_frame_sequencer_status_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the APU frame sequencer with status registers
// After reset, a short scripted run exercises register writes and reads, odd
// addresses and a full frame of ticks. Random words then follow under several
// sample periods, with random gaps on both sides and one long output stall.
// Each result word is checked against a fixed value or behavioural predictor.
// ----------------------------------------------------------------------------
module apu_frame_sequencer_status_tb;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam logic [15:0] AddrUnmapped = 16'h4016;
  localparam int unsigned PhaseWords   = 122;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned CycleLimit   = 400_000;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  cycles;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        p1;
    logic        p2;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       quarter;
    logic       half;
    logic       irq;
    logic [5:0] due;
    logic [4:0] enables;
  } status_word_t;

  typedef struct packed {
    bus_word_t    word;
    logic         typed;
    status_word_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [9:0]  cycles_i;
  logic [15:0] addr_i;
  logic [7:0]  wdata_i;
  logic        pulse1_length_active_i;
  logic        pulse2_length_active_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  read_data_o;
  logic        quarter_clock_o;
  logic        half_clock_o;
  logic        frame_irq_level_o;
  logic [5:0]  samples_due_o;
  logic [4:0]  channel_enable_bits_o;

  // Predictor state.
  logic [14:0] frame_count;
  logic        five_mode;
  logic        inhibit_set;
  logic        irq_flag;
  logic [31:0] sample_acc;
  logic [4:0]  chan_enables;
  logic [31:0] sample_period;

  status_word_t pending_status_q[$];
  script_row_t  script_rows[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  logic         calm = 1'b0;
  logic         hold_pending = 1'b0;

  apu_frame_sequencer_status dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .op_i                   (op_i),
    .cycles_i               (cycles_i),
    .addr_i                 (addr_i),
    .wdata_i                (wdata_i),
    .pulse1_length_active_i (pulse1_length_active_i),
    .pulse2_length_active_i (pulse2_length_active_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .read_data_o            (read_data_o),
    .quarter_clock_o        (quarter_clock_o),
    .half_clock_o           (half_clock_o),
    .frame_irq_level_o      (frame_irq_level_o),
    .samples_due_o          (samples_due_o),
    .channel_enable_bits_o  (channel_enable_bits_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic status_word_t frame_seq_step(input bus_word_t w);
    status_word_t r;
    int unsigned  step;
    int unsigned  from_cnt;
    int unsigned  to_cnt;
    int unsigned  frame_end;
    logic [63:0]  total;
    logic [63:0]  n;
    r = '0;
    if (w.op == apu_fs_pkg::OpTick && w.cycles != 10'd0) begin
      step = 32'((w.cycles > apu_fs_pkg::MaxStepCycles) ? apu_fs_pkg::MaxStepCycles
                                                         : w.cycles);
      from_cnt = 32'(frame_count);
      to_cnt = from_cnt + step;
      if (from_cnt < 32'(apu_fs_pkg::Mark0) && to_cnt >= 32'(apu_fs_pkg::Mark0)) begin
        r.quarter = 1'b1;
      end
      if (from_cnt < 32'(apu_fs_pkg::Mark1) && to_cnt >= 32'(apu_fs_pkg::Mark1)) begin
        r.quarter = 1'b1;
        r.half = 1'b1;
      end
      if (from_cnt < 32'(apu_fs_pkg::Mark2) && to_cnt >= 32'(apu_fs_pkg::Mark2)) begin
        r.quarter = 1'b1;
      end
      if (from_cnt < 32'(apu_fs_pkg::Mark3) && to_cnt >= 32'(apu_fs_pkg::Mark3)) begin
        r.quarter = 1'b1;
        r.half = 1'b1;
        if (!five_mode && !inhibit_set) irq_flag = 1'b1;
      end
      frame_end = 32'(five_mode ? apu_fs_pkg::End5 : apu_fs_pkg::Mark3);
      if (to_cnt >= frame_end) to_cnt = to_cnt - frame_end;
      frame_count = 15'(to_cnt);
      if (sample_period != 32'd0) begin
        total = 64'(sample_acc) + (64'(step) << 16);
        n = total / 64'(sample_period);
        if (n > 64'd63) n = 64'd63;
        total = total - n * 64'(sample_period);
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        sample_acc = total[31:0];
        r.due = n[5:0];
      end
    end else if (w.op == apu_fs_pkg::OpWrite) begin
      if (w.addr == apu_fs_pkg::AddrStatus) begin
        chan_enables = w.wdata[4:0];
      end else if (w.addr == apu_fs_pkg::AddrFrame) begin
        five_mode = w.wdata[apu_fs_pkg::BitMode];
        inhibit_set = w.wdata[apu_fs_pkg::BitInhibit];
        if (inhibit_set) irq_flag = 1'b0;
        frame_count = '0;
      end
    end else if (w.op == apu_fs_pkg::OpRead && w.addr == apu_fs_pkg::AddrStatus) begin
      r.read_data = {1'b0, irq_flag, 4'b0000, w.p2, w.p1};
      irq_flag = 1'b0;
    end
    r.irq = irq_flag;
    r.enables = chan_enables;
    return r;
  endfunction

  function automatic status_word_t quiet(input logic [7:0] rd, input logic irq,
                                         input logic [4:0] en);
    status_word_t r;
    r = '0;
    r.read_data = rd;
    r.irq = irq;
    r.enables = en;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [9:0] cyc,
                                  input logic [15:0] addr, input logic [7:0] wdata,
                                  input logic p1, input logic p2, input logic typed,
                                  input status_word_t want);
    script_row_t row;
    row.word = {op, cyc, addr, wdata, p1, p2};
    row.typed = typed;
    row.want = want;
    script_rows.push_back(row);
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t   w;
    int unsigned sel;
    w.op = apu_fs_pkg::OpTick;
    w.cycles = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(400, 1023));
    w.addr = 16'($urandom_range(0, 16'hFFFF));
    w.wdata = 8'($urandom_range(0, 8'hFF));
    w.p1 = 1'($urandom_range(0, 1));
    w.p2 = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 62) begin
      w.op = apu_fs_pkg::OpTick;
    end else if (sel < 66) begin
      w.op = apu_fs_pkg::OpWrite;
      w.addr = apu_fs_pkg::AddrFrame;
    end else if (sel < 76) begin
      w.op = apu_fs_pkg::OpWrite;
      w.addr = apu_fs_pkg::AddrStatus;
    end else if (sel < 88) begin
      w.op = apu_fs_pkg::OpRead;
      w.addr = apu_fs_pkg::AddrStatus;
    end else begin
      w.op = 2'($urandom_range(0, 3));
    end
    return w;
  endfunction

  task automatic offer_word(input bus_word_t w, input logic typed,
                            input status_word_t want);
    int unsigned  gap;
    status_word_t predicted;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i <= w.op;
    cycles_i <= w.cycles;
    addr_i <= w.addr;
    wdata_i <= w.wdata;
    pulse1_length_active_i <= w.p1;
    pulse2_length_active_i <= w.p2;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = frame_seq_step(w);
    pending_status_q.push_back(typed ? want : predicted);
  endtask

  task automatic program_sample_period(input logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sample_period = value;
  endtask

  initial begin : result_sink
    int unsigned  stall;
    status_word_t got;
    status_word_t want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HoldCycles;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = {read_data_o, quarter_clock_o, half_clock_o, frame_irq_level_o,
             samples_due_o, channel_enable_bits_o};
      if (pending_status_q.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_status_q.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
          mismatch_count++;
        end
        if (got.quarter !== want.quarter) begin
          $error("quarter_clock: expected %0b, got %0b", want.quarter, got.quarter);
          mismatch_count++;
        end
        if (got.half !== want.half) begin
          $error("half_clock: expected %0b, got %0b", want.half, got.half);
          mismatch_count++;
        end
        if (got.irq !== want.irq) begin
          $error("frame_irq_level: expected %0b, got %0b", want.irq, got.irq);
          mismatch_count++;
        end
        if (got.due !== want.due) begin
          $error("samples_due: expected %0d, got %0d", want.due, got.due);
          mismatch_count++;
        end
        if (got.enables !== want.enables) begin
          $error("channel_enable_bits: expected %0h, got %0h", want.enables,
                 got.enables);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] period_plan [6];
    bus_word_t   w;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= apu_fs_pkg::OpTick;
    cycles_i <= '0;
    addr_i <= '0;
    wdata_i <= '0;
    pulse1_length_active_i <= 1'b0;
    pulse2_length_active_i <= 1'b0;

    frame_count = '0;
    five_mode = 1'b0;
    inhibit_set = 1'b0;
    irq_flag = 1'b0;
    sample_acc = '0;
    chan_enables = '0;
    sample_period = apu_fs_pkg::CyclesPerSampleReset;

    period_plan[0] = 32'd1048576;
    period_plan[1] = 32'd0;
    period_plan[2] = 32'hFFFF_FFFF;
    period_plan[3] = apu_fs_pkg::CyclesPerSampleReset;
    period_plan[4] = $urandom_range(32'hFFFF_FFFF, 32'd1048576);
    period_plan[5] = $urandom_range(32'd8000000, 32'd1048576);

    // The last tick of the run of full ticks crosses the end of the frame.
    add_row(apu_fs_pkg::OpRead, 10'd0, apu_fs_pkg::AddrStatus, 8'h00, 1'b1, 1'b1, 1'b1,
            quiet(8'h03, 1'b0, 5'h00));
    add_row(apu_fs_pkg::OpWrite, 10'd0, apu_fs_pkg::AddrStatus, 8'hFF, 1'b0, 1'b0, 1'b1,
            quiet(8'h00, 1'b0, 5'h1F));
    add_row(apu_fs_pkg::OpWrite, 10'd0, apu_fs_pkg::AddrStatus, 8'hE0, 1'b0, 1'b0, 1'b1,
            quiet(8'h00, 1'b0, 5'h00));
    add_row(apu_fs_pkg::OpWrite, 10'd0, apu_fs_pkg::AddrStatus, 8'h0A, 1'b0, 1'b0, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));
    add_row(apu_fs_pkg::OpTick, 10'd0, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));
    add_row(OpUnused, 10'h3FF, apu_fs_pkg::AddrStatus, 8'hFF, 1'b1, 1'b1, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));
    add_row(apu_fs_pkg::OpWrite, 10'd0, AddrUnmapped, 8'hFF, 1'b0, 1'b0, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));
    add_row(apu_fs_pkg::OpRead, 10'd0, 16'hFFFF, 8'h00, 1'b1, 1'b1, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));
    add_row(apu_fs_pkg::OpWrite, 10'd0, apu_fs_pkg::AddrFrame, 8'h00, 1'b0, 1'b0, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));
    repeat (15) add_row(apu_fs_pkg::OpTick, 10'h3FF, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0,
                        '0);
    add_row(apu_fs_pkg::OpRead, 10'd0, apu_fs_pkg::AddrStatus, 8'h00, 1'b0, 1'b1, 1'b1,
            quiet(8'h42, 1'b0, 5'h0A));
    add_row(apu_fs_pkg::OpWrite, 10'd0, apu_fs_pkg::AddrFrame, 8'hC0, 1'b0, 1'b0, 1'b1,
            quiet(8'h00, 1'b0, 5'h0A));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_rows[i]) offer_word(script_rows[i].word, script_rows[i].typed,
                                        script_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      program_sample_period(period_plan[p]);
      calm = (p == 0 || p == 3);
      if (p == 0) hold_pending = 1'b1;
      for (int i = 0; i < PhaseWords; i++) begin
        w = random_word();
        offer_word(w, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/apu_fs_pkg.sv
hdl/apu_fs_ctrl.sv
hdl/apu_fs_dp.sv
hdl/apu_frame_sequencer_status.sv
bench/apu_frame_sequencer_status_tb.sv
